/* rtl/core/ssr_pkg.sv */
package ssr_pkg;

    // Framebuffer geometry.
    localparam int BUF_WIDTH  = 256;
    localparam int BUF_HEIGHT = 256;
    localparam int FB_DEPTH   = BUF_WIDTH * BUF_HEIGHT;
    localparam int FB_AW      = $clog2(FB_DEPTH);
    localparam int FB_XW      = $clog2(BUF_WIDTH);
    localparam int FB_YW      = $clog2(BUF_HEIGHT);

    // Signed coordinate wide enough for any position plus or minus an extent.
    localparam int COORD_W = 15;
    typedef logic signed [COORD_W-1:0] coord_t;
    localparam coord_t X_MAX = coord_t'(BUF_WIDTH - 1);
    localparam coord_t Y_MAX = coord_t'(BUF_HEIGHT - 1);

    // Fixed point: Q16 falloff, 25-bit roots of a 50-bit radicand.
    localparam int FRAC       = 16;
    localparam int T_W        = FRAC + 1;
    localparam int SQ_ROOT_W  = 25;
    localparam int SQ_RAD_W   = 2 * SQ_ROOT_W;
    localparam int DV_W       = 25;
    localparam logic [T_W-1:0] Q_ONE = T_W'(1 << FRAC);

    typedef logic [7:0] alpha_t;

    // Command codes.
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_CIRCLE = 3'd1;
    localparam logic [2:0] OP_RECT   = 3'd2;
    localparam logic [2:0] OP_CROSS  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

endpackage

/* rtl/core/ssr_sqrt.sv */
module ssr_sqrt
    import ssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQ_RAD_W-1:0]  radicand,
    output logic                 done,
    output logic [SQ_ROOT_W-1:0] root
);

    // Digit-by-digit square root, two radicand bits per cycle.
    localparam int CNT_W = $clog2(SQ_ROOT_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SQ_RAD_W-1:0]   rad_reg, rad_next;
    logic [SQ_ROOT_W+1:0]  rem_reg, rem_next;
    logic [SQ_ROOT_W-1:0]  root_reg, root_next;
    logic [SQ_ROOT_W+3:0]  rem_sh;
    logic [SQ_ROOT_W+3:0]  trial;

    assign rem_sh = {rem_reg, rad_reg[SQ_RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = (SQ_ROOT_W+2)'(rem_sh - trial);
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (SQ_ROOT_W+2)'(rem_sh);
                root_next = {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(SQ_ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/ssr_div.sv */
module ssr_div
    import ssr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DV_W-1:0] num,
    input  logic [DV_W-1:0] den,
    output logic            done,
    output logic [T_W-1:0]  t
);

    // Computes t = 1 - num/den in Q16, clamped at zero, one quotient bit per cycle.
    localparam int CNT_W = $clog2(FRAC);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DV_W-1:0]    rem_reg, rem_next;
    logic [DV_W-1:0]    den_reg, den_next;
    logic [FRAC-1:0]    q_reg, q_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [DV_W:0]      rem2;

    assign rem2 = {rem_reg, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        t_next    = t_reg;
        if (start)
        begin
            den_next = den;
            rem_next = num;
            q_next   = '0;
            cnt_next = '0;
            if (num >= den)
            begin
                t_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem2 >= {1'b0, den_reg})
            begin
                rem_next = DV_W'(rem2 - {1'b0, den_reg});
                q_next   = {q_reg[FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_next = DV_W'(rem2);
                q_next   = {q_reg[FRAC-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(FRAC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                t_next    = Q_ONE - {1'b0, q_next};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        t_reg   <= t_next;
    end

    assign done = done_reg;
    assign t    = t_reg;

endmodule

/* rtl/core/ssr_fb.sv */
module ssr_fb
    import ssr_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [FB_AW-1:0] waddr,
    input  alpha_t           wdata,
    input  logic [FB_AW-1:0] raddr,
    output alpha_t           rdata
);

    // Single-port-write, single-port-read alpha store with registered read data.
    alpha_t mem [FB_DEPTH];
    alpha_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/soft_alpha_shape_rasterizer_core.sv */
// Soft alpha shape rasterizer: holds a 256 x 256 alpha-only framebuffer and
// draws clears, filled circles, filled rectangles and soft plus signs into it
// with a max blend, and answers pixel reads with one result item each. After
// reset and after every clear command the block sweeps the whole store, one
// pixel per cycle, and is not ready until the sweep ends. Each circle or
// rectangle pixel starts the square root, waits for the square root unit and
// then for the falloff divider, and ends with a read-modify-write of the
// store; disc pixels outside the radius skip all of these. A rectangle first
// takes the root of its largest distance. A plus sign draws its centre disc
// that way and then its arms, with one divide for each pair of mirrored arm
// pixels plus one divide per arm row. Only one command is worked on at a
// time; a finished read result waits in an output register and a new command
// is taken meanwhile.
module soft_alpha_shape_rasterizer_core
    import ssr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [12:0] pos_x,
    input  logic signed [12:0] pos_y,
    input  logic [7:0]         extent_a,
    input  logic [7:0]         extent_b,
    input  logic [7:0]         peak_alpha,
    input  logic [7:0]         arm_peak_alpha,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         pixel_alpha,
    output logic               outside
);

    // Sequencer states.
    localparam logic [4:0] S_CLEAR      = 5'd0;
    localparam logic [4:0] S_IDLE       = 5'd1;
    localparam logic [4:0] S_DECODE     = 5'd2;
    localparam logic [4:0] S_READ       = 5'd3;
    localparam logic [4:0] S_READ_DATA  = 5'd4;
    localparam logic [4:0] S_RECT_MAXD  = 5'd5;
    localparam logic [4:0] S_MAXD_W     = 5'd6;
    localparam logic [4:0] S_SCAN_SET   = 5'd7;
    localparam logic [4:0] S_PIX        = 5'd8;
    localparam logic [4:0] S_SQRT_W     = 5'd9;
    localparam logic [4:0] S_DIV_W      = 5'd10;
    localparam logic [4:0] S_PUT_RD     = 5'd11;
    localparam logic [4:0] S_PUT_WR     = 5'd12;
    localparam logic [4:0] S_ARM_I      = 5'd13;
    localparam logic [4:0] S_ARM_LINE_W = 5'd14;
    localparam logic [4:0] S_ARM_J      = 5'd15;
    localparam logic [4:0] S_ARM_J_W    = 5'd16;

    // Where a pixel write returns to.
    localparam logic [1:0] PUT_SCAN = 2'd0;
    localparam logic [1:0] PUT_ARM0 = 2'd1;
    localparam logic [1:0] PUT_ARM1 = 2'd2;

    typedef logic signed [9:0] off_t;

    logic [4:0]       state_reg, state_next;
    logic [FB_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [2:0] op_reg, op_next;
    coord_t     cx_reg, cx_next;
    coord_t     cy_reg, cy_next;
    logic [7:0] ea_reg, ea_next;
    logic [7:0] eb_reg, eb_next;
    alpha_t     pa_reg, pa_next;
    alpha_t     aa_reg, aa_next;
    logic       rect_reg, rect_next;
    logic       cross_reg, cross_next;
    logic [8:0] r_reg, r_next;
    logic [SQ_ROOT_W-1:0] maxd_reg, maxd_next;
    coord_t     x0_reg, x0_next, x1_reg, x1_next;
    coord_t     y0_reg, y0_next, y1_reg, y1_next;
    coord_t     x_reg, x_next, y_reg, y_next;
    coord_t     px_reg, px_next, py_reg, py_next;
    off_t       i_reg, i_next, j_reg, j_next;
    alpha_t     line_reg, line_next;
    alpha_t     a_reg, a_next;
    logic [1:0] put_src_reg, put_src_next;
    alpha_t     pixel_alpha_reg, pixel_alpha_next;
    logic       outside_reg, outside_next;

    // Shared units and store.
    logic                 sq_start, sq_done;
    logic [SQ_RAD_W-1:0]  sq_rad;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic                 dv_start, dv_done;
    logic [DV_W-1:0]      dv_n, dv_d;
    logic [T_W-1:0]       dv_t;
    logic                 fb_we;
    logic [FB_AW-1:0]     fb_waddr, fb_raddr;
    alpha_t               fb_wdata, fb_rdata;

    // Per-pixel geometry.
    coord_t     rc, dx, dy, mdx, mdy, lo_x, hi_x, lo_y, hi_y;
    logic [8:0] adx, ady;
    logic [18:0] d2;
    logic [17:0] rsq, ssq;
    logic       scan_end;
    coord_t     adv_x, adv_y;
    off_t       ea_s, eb_s, mi, mj;
    logic       px_in, rd_in;

    function automatic logic in_buf(input coord_t x, input coord_t y);
        return (x >= 0) && (x <= X_MAX) && (y >= 0) && (y <= Y_MAX);
    endfunction

    function automatic logic [FB_AW-1:0] fb_addr(input coord_t x, input coord_t y);
        logic [FB_XW-1:0] xl;
        logic [FB_YW-1:0] yl;
        xl = x[FB_XW-1:0];
        yl = y[FB_YW-1:0];
        return FB_AW'(int'(yl) * BUF_WIDTH + int'(xl));
    endfunction

    // floor(alpha * t) with t in Q16.
    function automatic alpha_t scale(input alpha_t alpha, input logic [T_W-1:0] t);
        logic [T_W+7:0] p;
        p = (T_W+8)'(alpha) * (T_W+8)'(t);
        return p[FRAC+7:FRAC];
    endfunction

    ssr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    ssr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_n),
        .den   (dv_d),
        .done  (dv_done),
        .t     (dv_t)
    );

    ssr_fb u_fb (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    // Offsets of the current scan pixel. A disc uses the plain offset from
    // its centre; a rectangle uses doubled offsets from its half-pixel centre.
    assign rc  = coord_t'(r_reg);
    assign dx  = rect_reg ? coord_t'(((x_reg - cx_reg) <<< 1) - coord_t'(ea_reg))
                          : coord_t'(x_reg - cx_reg);
    assign dy  = rect_reg ? coord_t'(((y_reg - cy_reg) <<< 1) - coord_t'(eb_reg))
                          : coord_t'(y_reg - cy_reg);
    assign mdx = dx[COORD_W-1] ? coord_t'(-dx) : dx;
    assign mdy = dy[COORD_W-1] ? coord_t'(-dy) : dy;
    assign adx = mdx[8:0];
    assign ady = mdy[8:0];
    assign d2  = 19'(18'(adx) * 18'(adx)) + 19'(18'(ady) * 18'(ady));
    assign rsq = 18'(r_reg) * 18'(r_reg);
    assign ssq = 18'(ea_reg) * 18'(ea_reg) + 18'(eb_reg) * 18'(eb_reg);

    // Scan bounds before clipping to the buffer.
    assign lo_x = rect_reg ? cx_reg : coord_t'(cx_reg - rc);
    assign hi_x = rect_reg ? coord_t'(cx_reg + coord_t'(ea_reg) - coord_t'(1))
                           : coord_t'(cx_reg + rc);
    assign lo_y = rect_reg ? cy_reg : coord_t'(cy_reg - rc);
    assign hi_y = rect_reg ? coord_t'(cy_reg + coord_t'(eb_reg) - coord_t'(1))
                           : coord_t'(cy_reg + rc);

    assign scan_end = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign adv_x    = (x_reg == x1_reg) ? x0_reg : coord_t'(x_reg + coord_t'(1));
    assign adv_y    = (x_reg == x1_reg) ? coord_t'(y_reg + coord_t'(1)) : y_reg;

    assign ea_s = off_t'({2'b00, ea_reg});
    assign eb_s = off_t'({2'b00, eb_reg});
    assign mi   = i_reg[9] ? off_t'(-i_reg) : i_reg;
    assign mj   = j_reg[9] ? off_t'(-j_reg) : j_reg;

    assign px_in = in_buf(px_reg, py_reg);
    assign rd_in = in_buf(cx_reg, cy_reg);

    assign fb_raddr = (state_reg == S_READ) ? fb_addr(cx_reg, cy_reg)
                                            : fb_addr(px_reg, py_reg);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        op_next          = op_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        ea_next          = ea_reg;
        eb_next          = eb_reg;
        pa_next          = pa_reg;
        aa_next          = aa_reg;
        rect_next        = rect_reg;
        cross_next       = cross_reg;
        r_next           = r_reg;
        maxd_next        = maxd_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y0_next          = y0_reg;
        y1_next          = y1_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        line_next        = line_reg;
        a_next           = a_reg;
        put_src_next     = put_src_reg;
        pixel_alpha_next = pixel_alpha_reg;
        outside_next     = outside_reg;
        sq_start         = 1'b0;
        sq_rad           = '0;
        dv_start         = 1'b0;
        dv_n             = '0;
        dv_d             = '0;
        fb_we            = 1'b0;
        fb_waddr         = fb_addr(px_reg, py_reg);
        fb_wdata         = a_reg;

        case (state_reg)
            S_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_waddr = clr_cnt_reg;
                fb_wdata = '0;
                if (clr_cnt_reg == FB_AW'(FB_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                clr_cnt_next = clr_cnt_reg + FB_AW'(1);
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    cx_next    = coord_t'(pos_x);
                    cy_next    = coord_t'(pos_y);
                    ea_next    = extent_a;
                    eb_next    = extent_b;
                    pa_next    = peak_alpha;
                    aa_next    = arm_peak_alpha;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rect_next  = 1'b0;
                cross_next = 1'b0;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                    OP_CIRCLE:
                    begin
                        r_next     = 9'(ea_reg);
                        state_next = (ea_reg == 8'd0) ? S_IDLE : S_SCAN_SET;
                    end
                    OP_RECT:
                    begin
                        rect_next  = 1'b1;
                        state_next = (ea_reg == 8'd0 || eb_reg == 8'd0) ? S_IDLE
                                                                        : S_RECT_MAXD;
                    end
                    OP_CROSS:
                    begin
                        // The centre disc has radius thickness + 1.
                        cross_next = 1'b1;
                        r_next     = 9'(eb_reg) + 9'd1;
                        state_next = S_SCAN_SET;
                    end
                    OP_READ:
                    begin
                        state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                // Issue the store read once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_READ_DATA;
                end
            end

            S_READ_DATA:
            begin
                out_valid_next   = 1'b1;
                pixel_alpha_next = rd_in ? fb_rdata : '0;
                outside_next     = !rd_in;
                state_next       = S_IDLE;
            end

            S_RECT_MAXD:
            begin
                sq_start   = 1'b1;
                sq_rad     = SQ_RAD_W'(ssq) << 31;
                state_next = S_MAXD_W;
            end

            S_MAXD_W:
            begin
                if (sq_done)
                begin
                    maxd_next  = sq_root;
                    state_next = S_SCAN_SET;
                end
            end

            S_SCAN_SET:
            begin
                x0_next = (lo_x < 0) ? coord_t'(0) : lo_x;
                y0_next = (lo_y < 0) ? coord_t'(0) : lo_y;
                x1_next = (hi_x > X_MAX) ? X_MAX : hi_x;
                y1_next = (hi_y > Y_MAX) ? Y_MAX : hi_y;
                x_next  = x0_next;
                y_next  = y0_next;
                if ((x0_next > x1_next) || (y0_next > y1_next))
                begin
                    // Nothing of the shape lies in the buffer.
                    i_next     = off_t'(-ea_s);
                    state_next = cross_reg ? S_ARM_I : S_IDLE;
                end
                else
                begin
                    state_next = S_PIX;
                end
            end

            S_PIX:
            begin
                if (!rect_reg && (19'(rsq) < d2))
                begin
                    // Outside the disc: step on at once.
                    if (scan_end)
                    begin
                        i_next     = off_t'(-ea_s);
                        state_next = cross_reg ? S_ARM_I : S_IDLE;
                    end
                    else
                    begin
                        x_next = adv_x;
                        y_next = adv_y;
                    end
                end
                else
                begin
                    sq_start   = 1'b1;
                    sq_rad     = rect_reg ? (SQ_RAD_W'(d2) << 30) : (SQ_RAD_W'(d2) << 32);
                    state_next = S_SQRT_W;
                end
            end

            S_SQRT_W:
            begin
                if (sq_done)
                begin
                    dv_start   = 1'b1;
                    dv_n       = DV_W'(sq_root);
                    dv_d       = rect_reg ? DV_W'(maxd_reg) : (DV_W'(r_reg) << FRAC);
                    state_next = S_DIV_W;
                end
            end

            S_DIV_W:
            begin
                if (dv_done)
                begin
                    a_next       = scale(pa_reg, dv_t);
                    px_next      = x_reg;
                    py_next      = y_reg;
                    put_src_next = PUT_SCAN;
                    state_next   = S_PUT_RD;
                end
            end

            S_PUT_RD:
            begin
                state_next = S_PUT_WR;
            end

            S_PUT_WR:
            begin
                // Max blend; pixels off the buffer are dropped.
                if (px_in && (a_reg > fb_rdata))
                begin
                    fb_we = 1'b1;
                end
                case (put_src_reg)
                    PUT_SCAN:
                    begin
                        if (scan_end)
                        begin
                            i_next     = off_t'(-ea_s);
                            state_next = cross_reg ? S_ARM_I : S_IDLE;
                        end
                        else
                        begin
                            x_next     = adv_x;
                            y_next     = adv_y;
                            state_next = S_PIX;
                        end
                    end
                    PUT_ARM0:
                    begin
                        // Mirror pixel on the vertical arm.
                        px_next      = coord_t'(cx_reg + coord_t'(j_reg));
                        py_next      = coord_t'(cy_reg + coord_t'(i_reg));
                        put_src_next = PUT_ARM1;
                        state_next   = S_PUT_RD;
                    end
                    PUT_ARM1:
                    begin
                        if (j_reg == eb_s)
                        begin
                            if (i_reg == ea_s)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                i_next     = off_t'(i_reg + off_t'(1));
                                state_next = S_ARM_I;
                            end
                        end
                        else
                        begin
                            j_next     = off_t'(j_reg + off_t'(1));
                            state_next = S_ARM_J;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ARM_I:
            begin
                if (ea_reg == 8'd0)
                begin
                    // Zero arm length keeps the full line alpha.
                    line_next  = aa_reg;
                    j_next     = off_t'(-eb_s);
                    state_next = S_ARM_J;
                end
                else
                begin
                    dv_start   = 1'b1;
                    dv_n       = DV_W'(mi[7:0]);
                    dv_d       = DV_W'(ea_reg);
                    state_next = S_ARM_LINE_W;
                end
            end

            S_ARM_LINE_W:
            begin
                if (dv_done)
                begin
                    line_next  = scale(aa_reg, dv_t);
                    j_next     = off_t'(-eb_s);
                    state_next = S_ARM_J;
                end
            end

            S_ARM_J:
            begin
                dv_start   = 1'b1;
                dv_n       = DV_W'(mj[7:0]);
                dv_d       = DV_W'(9'(eb_reg) + 9'd1);
                state_next = S_ARM_J_W;
            end

            S_ARM_J_W:
            begin
                if (dv_done)
                begin
                    a_next       = scale(line_reg, dv_t);
                    px_next      = coord_t'(cx_reg + coord_t'(i_reg));
                    py_next      = coord_t'(cy_reg + coord_t'(j_reg));
                    put_src_next = PUT_ARM0;
                    state_next   = S_PUT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        ea_reg          <= ea_next;
        eb_reg          <= eb_next;
        pa_reg          <= pa_next;
        aa_reg          <= aa_next;
        rect_reg        <= rect_next;
        cross_reg       <= cross_next;
        r_reg           <= r_next;
        maxd_reg        <= maxd_next;
        x0_reg          <= x0_next;
        x1_reg          <= x1_next;
        y0_reg          <= y0_next;
        y1_reg          <= y1_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        line_reg        <= line_next;
        a_reg           <= a_next;
        put_src_reg     <= put_src_next;
        pixel_alpha_reg <= pixel_alpha_next;
        outside_reg     <= outside_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign pixel_alpha = pixel_alpha_reg;
    assign outside     = outside_reg;

endmodule

/* rtl/core/ssr_checker.sv */
module ssr_props
    import ssr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_alpha,
    input logic       outside
);

    // The block is held in its clear state while reset is held, so no item is taken.
    a_no_ready_in_reset: assert property (@(posedge clk) !rst_n |-> !in_ready)
        else $error("in_ready high during reset");

    // Every accepted item leaves the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready again right after an accepted item");

    // A result only appears while a command is being worked on.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // An outside read always returns zero alpha.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outside |-> pixel_alpha == 8'd0)
        else $error("outside read with nonzero alpha");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_alpha) && $stable(outside))
        else $error("stalled result changed");

endmodule

bind soft_alpha_shape_rasterizer_core ssr_props u_ssr_props (.*);
